@@ design/mcfp_pkg.sv @@
// Shared types and constants of the motor command frame parser.
// Used by every module of the block but the port checker; depends on nothing else.
`default_nettype none

package mcfp_pkg;

	localparam int unsigned CHAR_W  = 8;
	localparam int unsigned POS_W   = 3;
	localparam int unsigned SPEED_W = 8;
	localparam int unsigned ANGLE_W = 6;

	// A frame holds exactly this many characters; the position counter stops here.
	localparam logic [POS_W-1:0] FRAME_LEN = 3'd7;
	localparam logic [POS_W-1:0] POS_LAST  = 3'd6;

	localparam logic [SPEED_W-1:0] SPEED_RESET = 8'd100;
	localparam logic [ANGLE_W-1:0] ANGLE_MAX   = 6'd45;

	localparam logic [CHAR_W-1:0] CH_0 = 8'h30;
	localparam logic [CHAR_W-1:0] CH_1 = 8'h31;
	localparam logic [CHAR_W-1:0] CH_4 = 8'h34;
	localparam logic [CHAR_W-1:0] CH_9 = 8'h39;
	localparam logic [CHAR_W-1:0] CH_F = 8'h46;
	localparam logic [CHAR_W-1:0] CH_B = 8'h42;
	localparam logic [CHAR_W-1:0] CH_L = 8'h4C;
	localparam logic [CHAR_W-1:0] CH_R = 8'h52;

	// Working state of the frame that is being received.
	typedef struct packed {
		logic [POS_W-1:0]   pos;
		logic               bad;
		logic [SPEED_W-1:0] speed;
		logic               anticw;
		logic [ANGLE_W-1:0] angle;
		logic               left;
	} work_t;

	// Motor settings as carried by a frame and as applied.
	typedef struct packed {
		logic [SPEED_W-1:0] speed;
		logic               anticw;
		logic [ANGLE_W-1:0] angle;
		logic               left;
	} settings_t;

endpackage

`default_nettype wire

@@ design/mcfp_char_check.sv @@
// Per-position character check and decimal accumulation of one frame character.
// Purely combinational; uses mcfp_pkg.
`default_nettype none

module mcfp_char_check (
	input  wire logic [mcfp_pkg::CHAR_W-1:0] char_in,
	input  wire mcfp_pkg::work_t             work_cur,
	output mcfp_pkg::work_t                  work_next
);
	import mcfp_pkg::*;

	logic                is_dec;
	logic [3:0]          digit;
	logic [SPEED_W-1:0]  speed_x10;
	logic [ANGLE_W-1:0]  angle_x10;
	logic [ANGLE_W-1:0]  angle_sum;
	logic                ok;

	assign is_dec    = (char_in >= CH_0) && (char_in <= CH_9);
	assign digit     = char_in[3:0];
	// Multiply by ten as a sum of two shifts.
	assign speed_x10 = {work_cur.speed[SPEED_W-4:0], 3'b000}
		+ {work_cur.speed[SPEED_W-2:0], 1'b0};
	assign angle_x10 = {work_cur.angle[ANGLE_W-4:0], 3'b000}
		+ {work_cur.angle[ANGLE_W-2:0], 1'b0};
	assign angle_sum = angle_x10 + {2'b00, digit};

	always_comb begin
		work_next = work_cur;
		ok        = 1'b0;
		unique case (work_cur.pos)
			3'd0: begin
				ok = (char_in == CH_0) || (char_in == CH_1);
				if (ok) begin
					work_next.speed = {7'd0, char_in[0]};
				end
			end
			3'd1, 3'd2: begin
				ok = is_dec;
				if (ok) begin
					work_next.speed = speed_x10 + {4'd0, digit};
				end
			end
			3'd3: begin
				ok = (char_in == CH_F) || (char_in == CH_B);
				if (ok) begin
					work_next.anticw = (char_in == CH_F);
				end
			end
			3'd4: begin
				ok = (char_in >= CH_0) && (char_in <= CH_4);
				if (ok) begin
					work_next.angle = {2'b00, digit};
				end
			end
			3'd5: begin
				// Tens digit is at most four, so the sum never exceeds 49.
				ok = is_dec && (angle_sum <= ANGLE_MAX);
				if (ok) begin
					work_next.angle = angle_sum;
				end
			end
			3'd6: begin
				ok = (char_in == CH_L) || (char_in == CH_R);
				if (ok) begin
					work_next.left = (char_in == CH_L);
				end
			end
			default: begin
				ok = 1'b0;
			end
		endcase
		if (!ok) begin
			work_next.bad = 1'b1;
		end
		if (work_cur.pos != FRAME_LEN) begin
			work_next.pos = work_cur.pos + 3'd1;
		end
	end

endmodule

`default_nettype wire

@@ design/mcfp_result_reg.sv @@
// Applied motor settings and the result register of the frame parser.
// Takes the finished frame's verdict and settings; uses mcfp_pkg.
`default_nettype none

module mcfp_result_reg (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                take,
	input  wire logic                frame_ok,
	input  wire mcfp_pkg::settings_t frame_set,
	output logic                     out_free,
	output logic                     m_tvalid,
	input  wire logic                m_tready,
	output mcfp_pkg::settings_t      out_set,
	output logic                     out_ok
);
	import mcfp_pkg::*;

	settings_t applied_q;
	settings_t applied_next;
	settings_t out_set_q;
	logic      out_ok_q;
	logic      m_tvalid_q;

	assign out_free     = !m_tvalid_q || m_tready;
	assign applied_next = frame_ok ? frame_set : applied_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			applied_q  <= '{speed: SPEED_RESET, anticw: 1'b0, angle: '0, left: 1'b0};
			m_tvalid_q <= 1'b0;
		end else begin
			if (take) begin
				applied_q  <= applied_next;
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			out_set_q <= applied_next;
			out_ok_q  <= frame_ok;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign out_set  = out_set_q;
	assign out_ok   = out_ok_q;

endmodule

`default_nettype wire

@@ design/motor_command_frame_parser.sv @@
// Top level of the motor command frame parser: input register and working state.
// Instantiates mcfp_char_check and mcfp_result_reg; uses mcfp_pkg.
`default_nettype none

// Takes one ASCII character per transaction, s_tlast on the last one of a frame.
// A frame is valid when it is exactly seven characters long: speed 000..199,
// F or B, angle 00..45, L or R. Each character passes an input register and is
// checked and accumulated from there; a character with s_tlast gives one
// result transaction whose m_tuser is 1 for an accepted frame, and whose m_tdata
// carries the applied settings, which only an accepted frame updates. One
// character is taken every cycle while s_tready is high. s_tready drops only
// while a result waits in the output register and the next character in the
// input register ends a frame.
module motor_command_frame_parser (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	input  wire logic [7:0]  s_tdata,  // [7:0] char_in
	input  wire logic        s_tlast,  // frame_end
	output logic             m_tvalid,
	input  wire logic        m_tready,
	// [7:0] dc_speed, [8] dc_anticlockwise, [14:9] step_angle, [15] step_left
	output logic [15:0]      m_tdata,
	output logic             m_tuser   // frame_ok
);
	import mcfp_pkg::*;

	logic              valid_s1;
	logic [CHAR_W-1:0] char_s1;
	logic              end_s1;
	work_t             work_q;
	work_t             work_next;
	logic              out_free;
	logic              advance;
	logic              take;
	logic              frame_ok;
	settings_t         frame_set;
	settings_t         out_set;

	mcfp_char_check u_check (
		.char_in   (char_s1),
		.work_cur  (work_q),
		.work_next (work_next)
	);

	// A frame-ending character needs room in the result register.
	assign advance  = valid_s1 && (!end_s1 || out_free);
	assign take     = advance && end_s1;
	assign s_tready = !valid_s1 || advance;

	assign frame_ok  = !work_next.bad && (work_q.pos == POS_LAST);
	assign frame_set = '{speed: work_next.speed, anticw: work_next.anticw,
		angle: work_next.angle, left: work_next.left};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			work_q   <= '0;
		end else begin
			if (s_tready) begin
				valid_s1 <= s_tvalid;
			end
			if (advance) begin
				work_q <= end_s1 ? '0 : work_next;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			char_s1 <= s_tdata;
			end_s1  <= s_tlast;
		end
	end

	mcfp_result_reg u_result (
		.clk       (clk),
		.arst_n    (arst_n),
		.take      (take),
		.frame_ok  (frame_ok),
		.frame_set (frame_set),
		.out_free  (out_free),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.out_set   (out_set),
		.out_ok    (m_tuser)
	);

	assign m_tdata = {out_set.left, out_set.angle, out_set.anticw, out_set.speed};

endmodule

`default_nettype wire

@@ design/mcfp_port_checker.sv @@
// Port-level checks of the motor command frame parser, bound to its top level.
// Sees only the top-level ports; depends on nothing else.
`default_nettype none

module mcfp_port_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        s_tready,
	input wire logic        m_tvalid,
	input wire logic        m_tready,
	input wire logic [15:0] m_tdata,
	input wire logic        m_tuser
);

	// A result that is not taken stays offered.
	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid)
		else $error("result transaction withdrawn while stalled");

	// A stalled result keeps its payload.
	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> $stable(m_tdata) && $stable(m_tuser))
		else $error("result payload changed while stalled");

	// The input side stalls only while a result is waiting on the output side.
	a_no_false_stall: assert property (@(posedge clk) disable iff (!arst_n)
		(!m_tvalid || m_tready) |-> s_tready)
		else $error("input stalled with a free result register");

	// Applied settings stay in their legal ranges whenever a result is offered.
	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> (m_tdata[7:0] <= 8'd199) && (m_tdata[14:9] <= 6'd45))
		else $error("applied settings out of range");

endmodule

bind motor_command_frame_parser mcfp_port_checker u_mcfp_port_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.s_tready (s_tready),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata),
	.m_tuser  (m_tuser)
);

`default_nettype wire

@@ tb/testbench.sv @@
// Self-checking testbench of the motor command frame parser.
// Sends directed and random command frames and checks every result transaction
// against a behavioral model kept here; depends on mcfp_pkg and the parser RTL.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import mcfp_pkg::*;

	// Same bit order as m_tdata, highest field first.
	typedef struct packed {
		logic               left;
		logic [ANGLE_W-1:0] angle;
		logic               anticw;
		logic [SPEED_W-1:0] speed;
	} motor_setting_t;

	typedef struct packed {
		logic           ok;
		motor_setting_t setting;
	} frame_verdict_t;

	typedef struct packed {
		logic [CHAR_W-1:0] ch;
		logic              last;
		logic              typed;
		frame_verdict_t    verdict;
	} stim_row_t;

	localparam int CYCLE_LIMIT  = 200000;
	localparam int RANDOM_CHARS = 1000;
	localparam int LONG_STALL   = 300;

	localparam frame_verdict_t NO_VERDICT   = '0;
	localparam frame_verdict_t RESET_REJECT = '{ok: 1'b0,
		setting: '{left: 1'b0, angle: '0, anticw: 1'b0, speed: SPEED_RESET}};
	localparam frame_verdict_t FASTEST_OK   = '{ok: 1'b1,
		setting: '{left: 1'b1, angle: ANGLE_MAX, anticw: 1'b1, speed: 8'd199}};
	localparam frame_verdict_t FASTEST_KEPT = '{ok: 1'b0,
		setting: '{left: 1'b1, angle: ANGLE_MAX, anticw: 1'b1, speed: 8'd199}};

	localparam stim_row_t DIRECTED [23] = '{
		// A lone byte with every bit set: too short, settings still at reset.
		'{8'hFF, 1'b1, 1'b1, RESET_REJECT},
		// Largest speed and angle, both directions set.
		'{CH_1, 1'b0, 1'b0, NO_VERDICT},
		'{CH_9, 1'b0, 1'b0, NO_VERDICT},
		'{CH_9, 1'b0, 1'b0, NO_VERDICT},
		'{CH_F, 1'b0, 1'b0, NO_VERDICT},
		'{CH_4, 1'b0, 1'b0, NO_VERDICT},
		'{CH_0 + 8'd5, 1'b0, 1'b0, NO_VERDICT},
		'{CH_L, 1'b1, 1'b1, FASTEST_OK},
		// Angle of 46 is over the bound, so the frame is rejected.
		'{CH_0, 1'b0, 1'b0, NO_VERDICT},
		'{CH_0, 1'b0, 1'b0, NO_VERDICT},
		'{CH_0, 1'b0, 1'b0, NO_VERDICT},
		'{CH_B, 1'b0, 1'b0, NO_VERDICT},
		'{CH_4, 1'b0, 1'b0, NO_VERDICT},
		'{CH_0 + 8'd6, 1'b0, 1'b0, NO_VERDICT},
		'{CH_R, 1'b1, 1'b1, FASTEST_KEPT},
		// A good frame followed by a NUL runs one character too long.
		'{CH_0, 1'b0, 1'b0, NO_VERDICT},
		'{CH_0, 1'b0, 1'b0, NO_VERDICT},
		'{CH_0, 1'b0, 1'b0, NO_VERDICT},
		'{CH_B, 1'b0, 1'b0, NO_VERDICT},
		'{CH_0, 1'b0, 1'b0, NO_VERDICT},
		'{CH_0, 1'b0, 1'b0, NO_VERDICT},
		'{CH_R, 1'b0, 1'b0, NO_VERDICT},
		'{8'h00, 1'b1, 1'b1, FASTEST_KEPT}
	};

	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata  = '0;  // [7:0] char_in
	logic        s_tlast  = 1'b0; // frame_end
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [15:0] m_tdata;         // [7:0] speed, [8] anticw, [14:9] angle, [15] left
	logic        m_tuser;         // frame_ok

	int send_idle     = 0;
	int recv_idle     = 0;
	int stall_request = 0;
	int mismatches    = 0;
	int cycles        = 0;

	frame_verdict_t    verdicts_due [$];
	logic [CHAR_W-1:0] frame_chars [$];

	// Model state: the frame being received and the settings in force.
	logic [3:0]         cmd_pos;
	logic               cmd_bad;
	logic [SPEED_W-1:0] speed_acc;
	logic               anticw_acc;
	logic [ANGLE_W-1:0] angle_acc;
	logic               left_acc;
	motor_setting_t     applied;

	motor_command_frame_parser i_dut (
		.clk,
		.arst_n,
		.s_tvalid,
		.s_tready,
		.s_tdata,
		.s_tlast,
		.m_tvalid,
		.m_tready,
		.m_tdata,
		.m_tuser
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	function automatic void clear_frame();
		cmd_pos    = '0;
		cmd_bad    = 1'b0;
		speed_acc  = '0;
		anticw_acc = 1'b0;
		angle_acc  = '0;
		left_acc   = 1'b0;
	endfunction

	// Checks and accumulates one character; returns 1 when it closes a frame.
	function automatic logic parse_command_char(input logic [CHAR_W-1:0] ch, input logic last,
			output frame_verdict_t verdict);
		logic              good;
		logic              at_last_pos;
		logic [CHAR_W-1:0] digit;
		int unsigned       angle_sum;

		digit     = ch - CH_0;
		angle_sum = angle_acc * 10 + digit;
		good      = 1'b0;
		case (cmd_pos)
			4'd0: begin
				good = (ch == CH_0) || (ch == CH_1);
				if (good) speed_acc = digit;
			end
			4'd1, 4'd2: begin
				good = (ch >= CH_0) && (ch <= CH_9);
				if (good) speed_acc = speed_acc * 8'd10 + digit;
			end
			4'd3: begin
				good = (ch == CH_F) || (ch == CH_B);
				if (good) anticw_acc = (ch == CH_F);
			end
			4'd4: begin
				good = (ch >= CH_0) && (ch <= CH_4);
				if (good) angle_acc = digit[ANGLE_W-1:0];
			end
			4'd5: begin
				good = (ch >= CH_0) && (ch <= CH_9) && (angle_sum <= ANGLE_MAX);
				if (good) angle_acc = angle_sum[ANGLE_W-1:0];
			end
			4'd6: begin
				good = (ch == CH_L) || (ch == CH_R);
				if (good) left_acc = (ch == CH_L);
			end
			default: good = 1'b0;
		endcase
		at_last_pos = (cmd_pos == 4'(POS_LAST));
		if (!good) cmd_bad = 1'b1;
		if (cmd_pos < 4'(FRAME_LEN)) cmd_pos = cmd_pos + 4'd1;
		verdict = NO_VERDICT;
		if (!last) return 1'b0;
		verdict.ok = !cmd_bad && at_last_pos;
		if (verdict.ok)
			applied = '{left: left_acc, angle: angle_acc, anticw: anticw_acc, speed: speed_acc};
		verdict.setting = applied;
		clear_frame();
		return 1'b1;
	endfunction

	// Mostly well-formed frames with random content, the rest broken or noise.
	function automatic void compose_random_frame();
		int unsigned       pick;
		int unsigned       spot;
		int unsigned       keep;
		logic [CHAR_W-1:0] tens;

		frame_chars.delete();
		tens = CH_0 + 8'($urandom_range(4));
		frame_chars.push_back(CH_0 + 8'($urandom_range(1)));
		frame_chars.push_back(CH_0 + 8'($urandom_range(9)));
		frame_chars.push_back(CH_0 + 8'($urandom_range(9)));
		frame_chars.push_back($urandom_range(1) ? CH_F : CH_B);
		frame_chars.push_back(tens);
		frame_chars.push_back(CH_0 + 8'((tens == CH_4) ? $urandom_range(5) : $urandom_range(9)));
		frame_chars.push_back($urandom_range(1) ? CH_L : CH_R);
		pick = $urandom_range(99);
		if (pick < 60) return;
		if (pick < 80) begin
			spot = $urandom_range(6);
			if ($urandom_range(1)) begin
				frame_chars[spot] = 8'($urandom_range(255));
			end else begin
				// Near misses; adding 8'h20 gives the lowercase letter.
				case (spot)
					0: frame_chars[0] = CH_0 + 8'($urandom_range(9, 2));
					1, 2: frame_chars[spot] = $urandom_range(1) ? CH_0 - 8'd1 : CH_9 + 8'd1;
					3: frame_chars[3] = $urandom_range(1) ? CH_L : CH_F + 8'h20;
					4: frame_chars[4] = CH_0 + 8'($urandom_range(9, 5));
					5: begin
						frame_chars[4] = CH_4;
						frame_chars[5] = CH_0 + 8'($urandom_range(9, 6));
					end
					default: frame_chars[6] = $urandom_range(1) ? CH_F : CH_R + 8'h20;
				endcase
			end
		end else if (pick < 90) begin
			keep = $urandom_range(6, 1);
			while (frame_chars.size() > keep) void'(frame_chars.pop_back());
		end else if (pick < 96) begin
			repeat ($urandom_range(3, 1)) frame_chars.push_back(8'($urandom_range(255)));
		end else begin
			frame_chars.delete();
			repeat ($urandom_range(9, 1)) frame_chars.push_back(8'($urandom_range(255)));
		end
	endfunction

	task automatic send_char(input logic [CHAR_W-1:0] ch, input logic last, input logic typed,
			input frame_verdict_t typed_verdict);
		frame_verdict_t predicted;

		while ($urandom_range(99) < send_idle) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tdata  <= ch;
		s_tlast  <= last;
		do @(posedge clk); while (!s_tready);
		if (parse_command_char(ch, last, predicted))
			verdicts_due.push_back(typed ? typed_verdict : predicted);
	endtask

	function automatic void compare_field(input string name, input int unsigned want,
			input int unsigned got);
		if (want != got) begin
			$display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
			mismatches++;
		end
	endfunction

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (verdicts_due.size() == 0) begin
				$display("%0t: unexpected result transaction, expected none, actual tuser %b tdata %h",
					$time, m_tuser, m_tdata);
				mismatches++;
			end else begin
				compare_field("frame_ok", verdicts_due[0].ok, m_tuser);
				compare_field("dc_speed", verdicts_due[0].setting.speed, m_tdata[7:0]);
				compare_field("dc_anticlockwise", verdicts_due[0].setting.anticw, m_tdata[8]);
				compare_field("step_angle", verdicts_due[0].setting.angle, m_tdata[14:9]);
				compare_field("step_left", verdicts_due[0].setting.left, m_tdata[15]);
				void'(verdicts_due.pop_front());
			end
		end
	end

	// Receiver: random backpressure, and one long hold-off on request.
	initial begin
		int hold;

		forever begin
			@(posedge clk);
			if (stall_request != 0) begin
				hold = stall_request;
				stall_request = 0;
				m_tready <= 1'b0;
				repeat (hold) @(posedge clk);
			end
			m_tready <= ($urandom_range(99) >= recv_idle);
		end
	end

	initial begin
		while (cycles < CYCLE_LIMIT) begin
			@(posedge clk);
			cycles++;
		end
		$display("FAIL");
		$finish;
	end

	initial begin
		int sent;

		clear_frame();
		applied = RESET_REJECT.setting;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		send_idle = 24;
		recv_idle = 49;
		foreach (DIRECTED[i])
			send_char(DIRECTED[i].ch, DIRECTED[i].last, DIRECTED[i].typed, DIRECTED[i].verdict);

		sent = 0;
		for (int phase = 0; phase < 3; phase++) begin
			case (phase)
				0: begin
					send_idle = 24;
					recv_idle = 49;
				end
				1: begin
					send_idle = 49;
					recv_idle = 24;
				end
				default: begin
					// No idling here, so the hold-off backs the parser up to its input.
					send_idle = 0;
					recv_idle = 0;
					stall_request = LONG_STALL;
				end
			endcase
			while (sent < RANDOM_CHARS * (phase + 1) / 3) begin
				compose_random_frame();
				foreach (frame_chars[k])
					send_char(frame_chars[k], k == frame_chars.size() - 1, 1'b0, NO_VERDICT);
				sent += frame_chars.size();
			end
		end
		s_tvalid <= 1'b0;

		while (verdicts_due.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);
		if (mismatches == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

endmodule
